// ----- rtl/core/owm_pkg.sv -----
// ----------------------------------------------------------------------------
// owm_pkg
// Shared types, constants and coefficient helpers for the omni wheel mixer.
// ----------------------------------------------------------------------------
`default_nettype none

package owm_pkg;

    // Coefficient fraction bits (Q format of the mixing matrix)
    localparam int COEF_FRAC_BITS = 12;

    // Command full scale; must be a power of two so the final scale is a shift
    localparam int INPUT_FULL_SCALE = 128;
    localparam int FS_SHIFT         = $clog2(INPUT_FULL_SCALE);

    // Configuration register indexes
    localparam logic [1:0] REG_FOUR_WHEEL = 2'd0;
    localparam logic [1:0] REG_INVERT     = 2'd1;
    localparam logic [1:0] REG_MAX_PWM    = 2'd2;

    localparam logic [7:0] MAX_PWM_RESET = 8'd255;

    // Command beat
    typedef struct packed {
        logic signed [7:0] vel_x;
        logic signed [7:0] vel_y;
        logic signed [7:0] vel_rot;
    } in_t;

    // Result beat
    typedef struct packed {
        logic [7:0] duty_a;
        logic [7:0] duty_b;
        logic [7:0] duty_c;
        logic [7:0] duty_d;
        logic       dir_a;
        logic       dir_b;
        logic       dir_c;
        logic       dir_d;
    } out_t;

    // Round-to-nearest of milli / 1000 in Q.frac
    function automatic int coef_milli(input int milli, input int frac);
        coef_milli = ((milli << frac) + 500) / 1000;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/omni_wheel_mixer.sv -----
// ----------------------------------------------------------------------------
// omni_wheel_mixer
// Inverse kinematics for a three- or four-wheel omni drive: velocity command
// in, per-wheel PWM duty and direction out.
// ----------------------------------------------------------------------------
// Five register stages; one command beat accepted every cycle unless a stalled
// output has backed up every stage. A beat passes through stages 1 to 4 into
// the output register, where it appears as the result beat.
// Throughput is set by the stage chain itself: each stage holds one beat and
// passes it on whenever the stage after it is empty or moving, so bubbles are
// squeezed out and a stalled output only holds back the beats behind it.
// Stages: (1) axis sign convention, (2) constant coefficient products and the
// four-wheel row sums, (3) wheel speed sums and direction, (4) |speed| times
// max_pwm, (5) round half away from zero, clamp to 0..255, output register.
// Configuration is a plain write port (cfg_we/cfg_index/cfg_data) and is to
// be changed only while no beat is in flight; writes to an unused index are
// dropped. In three-wheel mode wheel D reports duty 0 and direction 0.
// ----------------------------------------------------------------------------
`default_nettype none

module omni_wheel_mixer #(
    parameter int COEF_FRAC_BITS = owm_pkg::COEF_FRAC_BITS
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire owm_pkg::in_t  in_data,
    output logic               out_valid,
    input  wire logic          out_ready,
    output owm_pkg::out_t      out_data,
    input  wire logic          cfg_we,
    input  wire logic [1:0]    cfg_index,
    input  wire logic [7:0]    cfg_data
);

    localparam int F      = COEF_FRAC_BITS;
    localparam int STAGES = 5;
    // Speed sums stay below 2^(F+8) in magnitude; one guard bit on top
    localparam int SW     = F + 10;
    localparam int MW     = SW - 1 + 8;            // |speed| * max_pwm
    localparam int SH     = F + owm_pkg::FS_SHIFT; // divide by full scale << F
    localparam int QW     = 11;                    // four-wheel row sums

    localparam logic signed [F:0] K667 = (F+1)'(owm_pkg::coef_milli(667, F));
    localparam logic signed [F:0] K577 = (F+1)'(owm_pkg::coef_milli(577, F));
    localparam logic signed [F:0] K333 = (F+1)'(owm_pkg::coef_milli(333, F));
    localparam logic signed [F:0] K330 = (F+1)'(owm_pkg::coef_milli(330, F));

    localparam logic [MW-1:0] HALF    = MW'(1) << (SH - 1);
    localparam logic [MW-1:0] DUTY_MAX = MW'(255);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic       four_wheel_reg;
    logic       invert_reg;
    logic [7:0] max_pwm_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            four_wheel_reg <= 1'b0;
            invert_reg     <= 1'b0;
            max_pwm_reg    <= owm_pkg::MAX_PWM_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                owm_pkg::REG_FOUR_WHEEL: four_wheel_reg <= cfg_data[0];
                owm_pkg::REG_INVERT:     invert_reg     <= cfg_data[0];
                owm_pkg::REG_MAX_PWM:    max_pwm_reg    <= cfg_data;
                default:                 ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control: a stage loads when it is empty or its
    // successor is loading. Valid bits ride along with the data.
    // ------------------------------------------------------------------
    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES-1:0] load;

    always_comb
    begin
        load[STAGES-1] = !valid_reg[STAGES-1] || out_ready;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            load[k] = !valid_reg[k] || load[k+1];
        end
        valid_next[0] = load[0] ? in_valid : valid_reg[0];
        for (int k = 1; k < STAGES; k++)
        begin
            valid_next[k] = load[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign in_ready  = load[0];
    assign out_valid = valid_reg[STAGES-1];

    // ------------------------------------------------------------------
    // Stage 1: sign convention. Default flips y, inverted flips x.
    // Negating -128 needs the ninth bit.
    // ------------------------------------------------------------------
    logic signed [8:0] s1_x_reg, s1_y_reg, s1_w_reg;
    logic              s1_four_reg;
    logic signed [8:0] vx, vy;

    always_comb
    begin
        vx = 9'(in_data.vel_x);
        vy = 9'(in_data.vel_y);
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            s1_x_reg    <= invert_reg ? -vx : vx;
            s1_y_reg    <= invert_reg ? vy : -vy;
            s1_w_reg    <= 9'(in_data.vel_rot);
            s1_four_reg <= four_wheel_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: three-wheel products and four-wheel row sums
    // ------------------------------------------------------------------
    logic signed [SW-1:0] s2_x667_reg, s2_x333_reg, s2_y577_reg, s2_w333_reg;
    logic signed [QW-1:0] s2_row_reg [4];
    logic                 s2_four_reg;
    logic signed [QW-1:0] qx, qy, qw;

    always_comb
    begin
        qx = QW'(s1_x_reg);
        qy = QW'(s1_y_reg);
        qw = QW'(s1_w_reg);
    end

    always_ff @(posedge clk)
    begin
        if (load[1])
        begin
            s2_x667_reg   <= SW'(s1_x_reg) * SW'(K667);
            s2_x333_reg   <= SW'(s1_x_reg) * SW'(K333);
            s2_y577_reg   <= SW'(s1_y_reg) * SW'(K577);
            s2_w333_reg   <= SW'(s1_w_reg) * SW'(K333);
            s2_row_reg[0] <= -qx - qy - qw;
            s2_row_reg[1] <= -qx + qy - qw;
            s2_row_reg[2] <=  qx - qy - qw;
            s2_row_reg[3] <=  qx + qy - qw;
            s2_four_reg   <= s1_four_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: wheel speeds and direction bits
    // ------------------------------------------------------------------
    logic signed [SW-1:0] s3_speed_reg [4];
    logic [3:0]           s3_dir_reg;
    logic signed [SW-1:0] speed [4];
    logic [3:0]           dir;

    always_comb
    begin
        if (s2_four_reg)
        begin
            for (int k = 0; k < 4; k++)
            begin
                speed[k] = SW'(s2_row_reg[k]) * SW'(K330);
                dir[k]   = (speed[k] <= 0);
            end
        end
        else
        begin
            speed[0] = s2_x667_reg + s2_w333_reg;
            speed[1] = -s2_x333_reg - s2_y577_reg + s2_w333_reg;
            speed[2] = -s2_x333_reg + s2_y577_reg + s2_w333_reg;
            speed[3] = '0;   // unused wheel
            for (int k = 0; k < 3; k++)
            begin
                dir[k] = (speed[k] >= 0);
            end
            dir[3] = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[2])
        begin
            s3_speed_reg <= speed;
            s3_dir_reg   <= dir;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: |speed| * max_pwm
    // ------------------------------------------------------------------
    logic [MW-1:0]   s4_prod_reg [4];
    logic [3:0]      s4_dir_reg;
    logic [SW-1:0]   abs_speed [4];

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            abs_speed[k] = s3_speed_reg[k][SW-1] ? SW'(-s3_speed_reg[k])
                                                 : SW'(s3_speed_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[3])
        begin
            for (int k = 0; k < 4; k++)
            begin
                s4_prod_reg[k] <= MW'(abs_speed[k][SW-2:0]) * MW'(max_pwm_reg);
            end
            s4_dir_reg <= s3_dir_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: round half away from zero (on the magnitude), clamp, output
    // ------------------------------------------------------------------
    logic [MW-1:0] scaled [4];
    logic [7:0]    duty [4];
    owm_pkg::out_t out_data_reg;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            scaled[k] = (s4_prod_reg[k] + HALF) >> SH;
            duty[k]   = (scaled[k] > DUTY_MAX) ? 8'd255 : scaled[k][7:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[4])
        begin
            out_data_reg.duty_a <= duty[0];
            out_data_reg.duty_b <= duty[1];
            out_data_reg.duty_c <= duty[2];
            out_data_reg.duty_d <= duty[3];
            out_data_reg.dir_a  <= s4_dir_reg[0];
            out_data_reg.dir_b  <= s4_dir_reg[1];
            out_data_reg.dir_c  <= s4_dir_reg[2];
            out_data_reg.dir_d  <= s4_dir_reg[3];
        end
    end

    assign out_data = out_data_reg;

endmodule

`default_nettype wire

// ----- rtl/core/owm_checker.sv -----
// ----------------------------------------------------------------------------
// owm_checker
// Port-level assertions for the omni wheel mixer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module owm_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          in_ready,
    input wire logic          out_valid,
    input wire logic          out_ready,
    input wire owm_pkg::out_t out_data,
    input wire logic          cfg_we,
    input wire logic [1:0]    cfg_index,
    input wire logic [7:0]    cfg_data
);

    // Shadow of the mode and scale registers, seen from the write port
    logic       four_seen_reg;
    logic       pwm_zero_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            four_seen_reg <= 1'b0;
            pwm_zero_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                owm_pkg::REG_FOUR_WHEEL: four_seen_reg <= cfg_data[0];
                owm_pkg::REG_MAX_PWM:    pwm_zero_reg  <= (cfg_data == 8'd0);
                default:                 ;
            endcase
        end
    end

    // No result beat in the cycle after reset is seen
    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("out_valid high during reset");

    // A moving output never blocks the input side
    a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("in_ready low while output drains");

    // Three-wheel results leave wheel D idle
    a_wheel_d_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !four_seen_reg |-> out_data.duty_d == 8'd0 &&
        !out_data.dir_d)
        else $error("wheel D active in three-wheel mode");

    // Zero scale gives zero duty on every wheel
    a_zero_scale: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pwm_zero_reg |-> out_data.duty_a == 8'd0 &&
        out_data.duty_b == 8'd0 && out_data.duty_c == 8'd0 &&
        out_data.duty_d == 8'd0)
        else $error("non-zero duty with max_pwm of zero");

    // Stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat changed under stall");

endmodule

bind omni_wheel_mixer owm_checker u_owm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
);

`default_nettype wire

// ----- verif/omni_wheel_mixer_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// omni_wheel_mixer_tb
// Self-checking bench for the omni wheel mixer. Command beats are pushed in
// through the valid/ready input while random gaps and output stalls run. Each
// accepted command is mixed by a behavioural model of the wheel matrices, and
// the result is queued. Every output beat is then compared field by field
// with the oldest queued result. Register settings change only between
// phases, once the pipeline has drained.
// ----------------------------------------------------------------------------

module omni_wheel_mixer_tb;

    // Spare register index; writes to it must leave every setting alone
    localparam logic [1:0] REG_UNUSED = 2'd3;

    // Watchdog, far above the slowest legal run of this stimulus
    localparam int CYCLE_LIMIT = 600000;

    // Pipeline depth plus some slack, used after draining
    localparam int SETTLE_CYCLES = 8;

    // Mixing coefficients in Q.COEF_FRAC_BITS, rounded to nearest
    localparam longint K667 =
        ((longint'(667) << owm_pkg::COEF_FRAC_BITS) + 500) / 1000;
    localparam longint K577 =
        ((longint'(577) << owm_pkg::COEF_FRAC_BITS) + 500) / 1000;
    localparam longint K333 =
        ((longint'(333) << owm_pkg::COEF_FRAC_BITS) + 500) / 1000;
    localparam longint K330 =
        ((longint'(330) << owm_pkg::COEF_FRAC_BITS) + 500) / 1000;

    // Divisor taking |speed| * max_pwm back to a duty count
    localparam longint DUTY_DIV =
        longint'(owm_pkg::INPUT_FULL_SCALE) << owm_pkg::COEF_FRAC_BITS;

    // ------------------------------------------------------------------------
    // Clock, reset and block ports; every input is known from time zero
    // ------------------------------------------------------------------------
    logic          clk       = 1'b0;
    logic          rst_n     = 1'b0;
    logic          in_valid  = 1'b0;
    logic          in_ready;
    owm_pkg::in_t  in_data   = '0;
    logic          out_valid;
    logic          out_ready = 1'b0;
    owm_pkg::out_t out_data;
    logic          cfg_we    = 1'b0;
    logic [1:0]    cfg_index = '0;
    logic [7:0]    cfg_data  = '0;

    // Shadow of the block's registers, as left by reset
    logic       cfg_four_wheel = 1'b0;
    logic       cfg_invert     = 1'b0;
    logic [7:0] cfg_max_pwm    = owm_pkg::MAX_PWM_RESET;

    // Wheel results still owed by the block, oldest first
    owm_pkg::out_t wheel_results_q [$];

    int  mismatch_count = 0;
    int  cycle_count    = 0;

    // Idling controls shared between the sender, the receiver and the tests
    bit  tx_gaps_on   = 1'b0;
    bit  rx_stalls_on = 1'b0;
    int  hold_off_req = 0;
    int  hold_off_left = 0;
    int  stall_left   = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    omni_wheel_mixer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Behavioural mixer
    // ------------------------------------------------------------------------

    // |speed| * max_pwm, rounded half away from zero, clamped to 8 bits.
    // The speed is the exact fixed-point sum, so no rounding happens earlier.
    function automatic logic [7:0] wheel_duty(input longint speed);
        longint mag;
        longint q;
        mag = (speed < 0) ? -speed : speed;
        q   = (mag * longint'(cfg_max_pwm) + DUTY_DIV / 2) / DUTY_DIV;
        return (q > 255) ? 8'hFF : q[7:0];
    endfunction

    function automatic owm_pkg::out_t mix_wheels(input owm_pkg::in_t cmd);
        longint        x;
        longint        y;
        longint        w;
        longint        s [4];
        owm_pkg::out_t r;
        x = longint'($signed(cmd.vel_x));
        y = longint'($signed(cmd.vel_y));
        w = longint'($signed(cmd.vel_rot));
        // Axis convention: normally y is flipped, inverted mode flips x instead
        if (cfg_invert)
            x = -x;
        else
            y = -y;
        r = '0;
        if (cfg_four_wheel)
        begin
            s[0] = K330 * (-x - y - w);
            s[1] = K330 * (-x + y - w);
            s[2] = K330 * ( x - y - w);
            s[3] = K330 * ( x + y - w);
            r.duty_a = wheel_duty(s[0]);
            r.duty_b = wheel_duty(s[1]);
            r.duty_c = wheel_duty(s[2]);
            r.duty_d = wheel_duty(s[3]);
            // Four-wheel drives count zero and reverse as direction 1
            r.dir_a  = (s[0] <= 0);
            r.dir_b  = (s[1] <= 0);
            r.dir_c  = (s[2] <= 0);
            r.dir_d  = (s[3] <= 0);
        end
        else
        begin
            s[0] = K667 * x + K333 * w;
            s[1] = -K333 * x - K577 * y + K333 * w;
            s[2] = -K333 * x + K577 * y + K333 * w;
            r.duty_a = wheel_duty(s[0]);
            r.duty_b = wheel_duty(s[1]);
            r.duty_c = wheel_duty(s[2]);
            r.dir_a  = (s[0] >= 0);
            r.dir_b  = (s[1] >= 0);
            r.dir_c  = (s[2] >= 0);
            // wheel D stays all zero in three-wheel mode
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Reporting and checking
    // ------------------------------------------------------------------------

    // One line per mismatch, and every mismatch is counted.
    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic compare_field(input string name, input logic [7:0] got,
                                 input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task automatic check_wheel_beat(input owm_pkg::out_t got);
        owm_pkg::out_t want;
        if (wheel_results_q.size() == 0)
        begin
            report_mismatch("result beat with nothing outstanding");
        end
        else
        begin
            want = wheel_results_q.pop_front();
            compare_field("duty_a", got.duty_a, want.duty_a);
            compare_field("duty_b", got.duty_b, want.duty_b);
            compare_field("duty_c", got.duty_c, want.duty_c);
            compare_field("duty_d", got.duty_d, want.duty_d);
            compare_field("dir_a", 8'(got.dir_a), 8'(want.dir_a));
            compare_field("dir_b", 8'(got.dir_b), 8'(want.dir_b));
            compare_field("dir_c", 8'(got.dir_c), 8'(want.dir_c));
            compare_field("dir_d", 8'(got.dir_d), 8'(want.dir_d));
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver: checks each beat taken and decides out_ready for the next
    // edge. A long hold-off requested by a test is counted down here; other
    // stalls are random, mostly short with the odd long one. Signals are read
    // at the edge before the block's registers update, so the sampled values
    // are those the block saw.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            check_wheel_beat(out_data);

        if (hold_off_req > 0)
        begin
            hold_off_left = hold_off_req;
            hold_off_req  = 0;
        end

        if (hold_off_left > 0)
        begin
            hold_off_left--;
            out_ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            if (rx_stalls_on)
            begin
                case ($urandom_range(99)) inside
                    [0:19]:  stall_left = $urandom_range(3, 1);
                    [20:22]: stall_left = $urandom_range(40, 10);
                    default: stall_left = 0;
                endcase
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sender side helpers. All of these are entered at a rising edge and
    // return at one, so valid is only ever given one update per edge.
    // ------------------------------------------------------------------------

    function automatic int pick_gap();
        case ($urandom_range(99)) inside
            [0:54]:  return 0;
            [55:91]: return $urandom_range(3, 1);
            default: return $urandom_range(25, 6);
        endcase
    endfunction

    // Offer one command and hold it until the block takes it. Valid is left
    // high afterwards so a back-to-back beat needs no extra edge.
    task automatic send_cmd(input owm_pkg::in_t cmd);
        int gap;
        gap = tx_gaps_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= cmd;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        wheel_results_q.push_back(mix_wheels(cmd));
    endtask

    task automatic send_xyr(input int vx, input int vy, input int vr);
        owm_pkg::in_t cmd;
        cmd.vel_x   = 8'(vx);
        cmd.vel_y   = 8'(vy);
        cmd.vel_rot = 8'(vr);
        send_cmd(cmd);
    endtask

    // Stop offering, wait for every owed result, then let the pipe settle so
    // a register write cannot land on a beat in flight.
    task automatic drain_pipe();
        in_valid <= 1'b0;
        while (wheel_results_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        // only the register's own width is kept; the spare index does nothing
        case (idx)
            owm_pkg::REG_FOUR_WHEEL: cfg_four_wheel = data[0];
            owm_pkg::REG_INVERT:     cfg_invert     = data[0];
            owm_pkg::REG_MAX_PWM:    cfg_max_pwm    = data;
            default: ;
        endcase
    endtask

    // Extreme or near-zero speed for corner-heavy commands
    function automatic logic [7:0] pick_edge_speed();
        case ($urandom_range(4))
            0:       return 8'h80;
            1:       return 8'hFF;
            2:       return 8'h00;
            3:       return 8'h01;
            default: return 8'h7F;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset settings: three-wheel, normal axes, full-scale duty. Covers zero
    // speed (direction 1 in this mode) and full-scale commands; none of these
    // reaches the clamp on wheels B and C, where the row gain exceeds one.
    task automatic test_three_wheel_directed();
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
        send_xyr(0, 0, 0);
        send_xyr(127, 127, 127);
        send_xyr(-128, -128, -128);
        send_xyr(127, -128, 0);
        send_xyr(-128, 127, 0);
        send_xyr(0, 0, -128);
        send_xyr(-128, 0, 127);
        send_xyr(0, -128, 127);
        drain_pipe();
    endtask

    // Register decoding: the spare index must be ignored and the one-bit
    // registers must keep bit 0 only.
    task automatic test_register_writes();
        write_reg(REG_UNUSED, 8'h00);
        write_reg(owm_pkg::REG_FOUR_WHEEL, 8'hFE);
        write_reg(owm_pkg::REG_INVERT, 8'hFF);
        write_reg(owm_pkg::REG_MAX_PWM, 8'd1);
        send_xyr(1, 1, 1);
        send_xyr(-128, 127, -1);
        send_xyr(127, 0, 0);
        drain_pipe();
    endtask

    // Four-wheel matrix: zero speed gives direction 1, wheel D is live, and
    // a zero multiplier forces every duty to zero.
    task automatic test_four_wheel_directed();
        write_reg(owm_pkg::REG_FOUR_WHEEL, 8'h01);
        write_reg(owm_pkg::REG_INVERT, 8'h00);
        write_reg(owm_pkg::REG_MAX_PWM, 8'd255);
        send_xyr(0, 0, 0);
        send_xyr(127, 127, 127);
        send_xyr(-128, -128, -128);
        send_xyr(1, -1, 0);
        send_xyr(-128, 127, 127);
        send_xyr(127, -128, -128);
        drain_pipe();
        write_reg(owm_pkg::REG_MAX_PWM, 8'd0);
        send_xyr(-128, -128, 127);
        send_xyr(127, 127, -128);
        drain_pipe();
    endtask

    // The receiver holds off for a long stretch while commands keep coming,
    // so the pipeline fills and in_ready must drop without losing a beat.
    task automatic test_backpressure();
        owm_pkg::in_t cmd;
        write_reg(owm_pkg::REG_FOUR_WHEEL, 8'h00);
        write_reg(owm_pkg::REG_MAX_PWM, 8'd200);
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b1;
        hold_off_req = 300;
        repeat (80)
        begin
            cmd = owm_pkg::in_t'(24'($urandom));
            send_cmd(cmd);
        end
        drain_pipe();
    endtask

    // Random commands across a sweep of settings. Sender gaps are switched
    // off on some phases so there are runs of full-rate traffic too.
    task automatic test_random_sweep();
        owm_pkg::in_t cmd;
        logic [7:0]   pwm;
        for (int phase = 0; phase < 12; phase++)
        begin
            case (phase)
                2:       pwm = 8'd0;
                3:       pwm = 8'd1;
                4, 5:    pwm = 8'd255;
                6:       pwm = 8'd128;
                default: pwm = 8'($urandom);
            endcase
            // upper bits of the one-bit registers are random junk
            write_reg(owm_pkg::REG_FOUR_WHEEL, {7'($urandom), phase[0]});
            write_reg(owm_pkg::REG_INVERT, {7'($urandom), phase[1]});
            write_reg(owm_pkg::REG_MAX_PWM, pwm);
            write_reg(REG_UNUSED, 8'($urandom));

            tx_gaps_on   = (phase % 3 != 2);
            rx_stalls_on = (phase % 4 != 1);
            repeat (155)
            begin
                if ($urandom_range(9) == 0)
                begin
                    cmd.vel_x   = pick_edge_speed();
                    cmd.vel_y   = pick_edge_speed();
                    cmd.vel_rot = pick_edge_speed();
                end
                else
                begin
                    cmd = owm_pkg::in_t'(24'($urandom));
                end
                send_cmd(cmd);
            end
            drain_pipe();
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_three_wheel_directed();
        test_register_writes();
        test_four_wheel_directed();
        test_backpressure();
        test_random_sweep();

        // any stray beat after the drain is caught by the receiver
        repeat (SETTLE_CYCLES + 2) @(posedge clk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
